// ----- hw/rtl/robi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package robi_pkg;

  localparam int COORD_W = 20;
  localparam int ROT_W   = 20;
  localparam int T_W     = 24;
  localparam int CFG_W   = 60;
  localparam int NUM_CFG = 5;
  localparam int CFG_IDX_W = 3;

  // Rotation operand width: holds both origin - center and the direction.
  localparam int VEC_W     = (COORD_W + 1 > ROT_W) ? COORD_W + 1 : ROT_W + 1;
  localparam int ROT_OUT_W = VEC_W + 4;
  localparam int MAG_W     = ROT_OUT_W;
  localparam int INV_W     = 32;
  localparam int SLAB_W    = 32;
  localparam int TP_W      = T_W + ROT_W;

  // Reciprocal divider: 2^34 / |d|, restoring, seven quotient bits per stage.
  localparam int DIV_BITS = 35;
  localparam int DIV_STEP = 7;
  localparam int DIV_ST   = DIV_BITS / DIV_STEP;
  localparam logic [DIV_BITS-1:0] DIV_NUM = DIV_BITS'(64'd1 << 34);
  localparam logic signed [INV_W-1:0] INV_MAX = INV_W'(64'sd2147483647);
  localparam logic signed [T_W-1:0]   T_ONE   = T_W'(4096);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z  = 3'd4;

  // Pipeline stage map.
  localparam int ST_REL  = 0;
  localparam int ST_ROTA = 1;
  localparam int ST_ROTB = 2;
  localparam int ST_SLAB = 3;
  localparam int ST_DIV  = 4;
  localparam int ST_INV  = ST_DIV + DIV_ST;
  localparam int ST_MUL  = ST_INV + 1;
  localparam int ST_TSAT = ST_MUL + 1;
  localparam int ST_CLIP = ST_TSAT + 1;
  localparam int ST_TMUL = ST_CLIP + 1;
  localparam int ST_PT   = ST_TMUL + 1;
  localparam int ST_LROT = ST_PT + 1;
  localparam int ST_OUT  = ST_LROT + 2;
  localparam int NST     = ST_OUT + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [ROT_W-1:0]   dir_x;
    logic signed [ROT_W-1:0]   dir_y;
    logic signed [ROT_W-1:0]   dir_z;
    logic signed [T_W-1:0]     near_limit;
    logic signed [T_W-1:0]     far_limit;
  } ray_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [T_W-1:0]     hit_t;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [ROT_W-1:0]   normal_x;
    logic signed [ROT_W-1:0]   normal_y;
    logic signed [ROT_W-1:0]   normal_z;
  } ray_out_t;

  typedef struct {
    logic signed [COORD_W-1:0]   org [3];
    logic signed [ROT_W-1:0]     dir [3];
    logic signed [T_W-1:0]       near_v;
    logic signed [T_W-1:0]       far_v;
    logic signed [VEC_W-1:0]     rel [3];
    logic                        dneg [3];
    logic                        dzero [3];
    logic signed [SLAB_W-1:0]    a [3];
    logic signed [SLAB_W-1:0]    b [3];
    logic signed [INV_W-1:0]     inv [3];
    logic signed [63:0]          pa [3];
    logic signed [63:0]          pb [3];
    logic signed [T_W-1:0]       ta [3];
    logic signed [T_W-1:0]       tb [3];
    logic                        hit;
    logic signed [T_W-1:0]       t;
    logic signed [TP_W-1:0]      tp [3];
    logic signed [COORD_W-1:0]   pt [3];
    logic signed [ROT_W-1:0]     nrm [3];
  } pipe_t;

  function automatic logic signed [COORD_W-1:0] coord_field(input logic [CFG_W-1:0] r,
                                                            input int unsigned k);
    logic [127:0] ext;
    ext = {{(128-CFG_W){1'b0}}, r};
    if (k * COORD_W >= 64) return '0;
    return ext[k*COORD_W +: COORD_W];
  endfunction

  function automatic logic signed [ROT_W-1:0] rot_field(input logic [CFG_W-1:0] r,
                                                        input int unsigned k);
    return r[k*ROT_W +: ROT_W];
  endfunction

  function automatic logic signed [SLAB_W-1:0] sat_slab(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SLAB_W-1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return SLAB_W'(hi);
    if (x < lo) return SLAB_W'(lo);
    return SLAB_W'(x);
  endfunction

  function automatic logic signed [T_W-1:0] sat_t(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (T_W-1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return T_W'(hi);
    if (x < lo) return T_W'(lo);
    return T_W'(x);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_c(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (COORD_W-1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return COORD_W'(hi);
    if (x < lo) return COORD_W'(lo);
    return COORD_W'(x);
  endfunction

  function automatic logic signed [ROT_W-1:0] sat_r(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (ROT_W-1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return ROT_W'(hi);
    if (x < lo) return ROT_W'(lo);
    return ROT_W'(x);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/robi_rot.sv -----
`timescale 1ns / 1ps
`default_nettype none
// 3x3 rotation, floor(R * v / 2^18): products in one stage, sums in the next.
module robi_rot (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [1:0]                            en_i,
  input  logic signed [robi_pkg::ROT_W-1:0]     rot_i [3][3],
  input  logic signed [robi_pkg::VEC_W-1:0]     vec_i [3],
  output logic signed [robi_pkg::ROT_OUT_W-1:0] res_o [3]
);

  localparam int PROD_W = robi_pkg::ROT_W + robi_pkg::VEC_W;

  logic signed [PROD_W-1:0]   prod_q [3][3];
  logic signed [PROD_W+1:0]   sum_d [3];
  logic signed [robi_pkg::ROT_OUT_W-1:0] res_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (en_i[0]) prod_q[i][k] <= rot_i[i][k] * vec_i[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = (PROD_W+2)'(prod_q[i][0]) + (PROD_W+2)'(prod_q[i][1])
               + (PROD_W+2)'(prod_q[i][2]);
    end
  end

  // Drop the low 18 bits: a floor shift on two's complement.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en_i[1]) res_q[i] <= sum_d[i][PROD_W+1:18];
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ----- hw/rtl/robi_recip.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider for 2^34 / mag on three lanes.
module robi_recip (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [robi_pkg::DIV_ST-1:0]          en_i,
  input  logic [robi_pkg::MAG_W-1:0]           mag_i [3],
  output logic [robi_pkg::DIV_BITS-1:0]        quo_o [3]
);

  localparam int MW = robi_pkg::MAG_W;
  localparam int QB = robi_pkg::DIV_BITS;
  localparam int NS = robi_pkg::DIV_ST;
  localparam int SP = robi_pkg::DIV_STEP;

  logic [MW:0]   rem_q [NS][3];
  logic [QB-1:0] quo_q [NS][3];
  logic [MW-1:0] mag_q [NS][3];
  logic [MW:0]   rem_d [NS][3];
  logic [QB-1:0] quo_d [NS][3];
  logic [MW-1:0] mag_d [NS][3];

  always_comb begin
    logic [MW:0]   rem;
    logic [QB-1:0] quo;
    logic          ge;
    for (int s = 0; s < NS; s++) begin
      for (int i = 0; i < 3; i++) begin
        if (s == 0) begin
          rem = '0;
          quo = '0;
          mag_d[s][i] = mag_i[i];
        end else begin
          rem = rem_q[s-1][i];
          quo = quo_q[s-1][i];
          mag_d[s][i] = mag_q[s-1][i];
        end
        for (int j = 0; j < SP; j++) begin
          rem = {rem[MW-1:0], robi_pkg::DIV_NUM[QB-1-(s*SP+j)]};
          ge  = (rem >= {1'b0, mag_d[s][i]});
          if (ge) rem = rem - {1'b0, mag_d[s][i]};
          quo = {quo[QB-2:0], ge};
        end
        rem_d[s][i] = rem;
        quo_d[s][i] = quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      for (int i = 0; i < 3; i++) begin
        if (en_i[s]) begin
          rem_q[s][i] <= rem_d[s][i];
          quo_q[s][i] <= quo_d[s][i];
          mag_q[s][i] <= mag_d[s][i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) quo_o[i] = quo_q[NS-1][i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ray_oriented_box_intersect.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: one register per stage, 18 stages; the result of an accepted item is
// presented from the last stage register, OUT, until out_ready_i takes it.
// Throughput: one item per cycle while out_ready_i is high; each stage holds only while
// the stage after it is full and stalled, so bubbles collapse and the input keeps flowing.
// Reset: rst_ni (async, active low) empties the pipeline and clears all five
// configuration registers to zero; no clearing pass is needed.
module ray_oriented_box_intersect (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  robi_pkg::ray_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output robi_pkg::ray_out_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [robi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [robi_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int NST = robi_pkg::NST;

  // Configuration registers; the user must write them only while the pipeline is empty (not enforced here).
  logic [robi_pkg::CFG_W-1:0] cfg_q [robi_pkg::NUM_CFG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < robi_pkg::NUM_CFG; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        robi_pkg::CFG_CENTER: cfg_q[robi_pkg::CFG_CENTER] <= cfg_data_i;
        robi_pkg::CFG_HALF:   cfg_q[robi_pkg::CFG_HALF]   <= cfg_data_i;
        robi_pkg::CFG_ROW_X:  cfg_q[robi_pkg::CFG_ROW_X]  <= cfg_data_i;
        robi_pkg::CFG_ROW_Y:  cfg_q[robi_pkg::CFG_ROW_Y]  <= cfg_data_i;
        robi_pkg::CFG_ROW_Z:  cfg_q[robi_pkg::CFG_ROW_Z]  <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Decoded box: center, half extents and rotation rows.
  logic signed [robi_pkg::COORD_W-1:0] cen  [3];
  logic signed [robi_pkg::COORD_W-1:0] half [3];
  logic signed [robi_pkg::ROT_W-1:0]   rot  [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cen[i]  = robi_pkg::coord_field(cfg_q[robi_pkg::CFG_CENTER], i);
      half[i] = robi_pkg::coord_field(cfg_q[robi_pkg::CFG_HALF], i);
      for (int k = 0; k < 3; k++) begin
        rot[i][k] = robi_pkg::rot_field(cfg_q[int'(robi_pkg::CFG_ROW_X) + i], k);
      end
    end
  end

  // Stage valids and advance enables. A stage loads when it is empty or when
  // the stage after it loads too.
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
      end
    end
  end

  // Payload stage registers.
  robi_pkg::pipe_t pipe_q [NST];
  robi_pkg::pipe_t pipe_d [NST];

  // Rotation of origin - center and of the direction (stages ROTA/ROTB).
  logic signed [robi_pkg::VEC_W-1:0]     dir_vec [3];
  logic signed [robi_pkg::ROT_OUT_W-1:0] rot_p [3];
  logic signed [robi_pkg::ROT_OUT_W-1:0] rot_dd [3];
  logic signed [robi_pkg::ROT_OUT_W-1:0] rot_l [3];
  logic [robi_pkg::MAG_W-1:0]            mag [3];
  logic [robi_pkg::DIV_BITS-1:0]         quo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) dir_vec[i] = robi_pkg::VEC_W'(pipe_q[robi_pkg::ST_REL].dir[i]);
  end

  robi_rot u_rot_p (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[robi_pkg::ST_ROTB:robi_pkg::ST_ROTA]),
    .rot_i  (rot),
    .vec_i  (pipe_q[robi_pkg::ST_REL].rel),
    .res_o  (rot_p)
  );

  robi_rot u_rot_d (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[robi_pkg::ST_ROTB:robi_pkg::ST_ROTA]),
    .rot_i  (rot),
    .vec_i  (dir_vec),
    .res_o  (rot_dd)
  );

  logic [robi_pkg::MAG_W-1:0] mag_q [3];

  // Reciprocal of each local direction magnitude, fed from the SLAB stage register.
  robi_recip u_recip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[robi_pkg::ST_INV-1:robi_pkg::ST_DIV]),
    .mag_i  (mag_q),
    .quo_o  (quo)
  );

  // Rotation of the hit point back into box space for the face pick.
  robi_rot u_rot_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[robi_pkg::ST_LROT+1:robi_pkg::ST_LROT]),
    .rot_i  (rot),
    .vec_i  (pipe_q[robi_pkg::ST_PT].rel),
    .res_o  (rot_l)
  );

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en[robi_pkg::ST_SLAB]) mag_q[i] <= mag[i];
    end
  end

  always_comb begin
    logic signed [63:0] hw, pw, rv, nv, wide;
    logic signed [63:0] e [3];
    logic signed [robi_pkg::T_W-1:0] lo, hi;
    logic [robi_pkg::INV_W-2:0] qm;
    logic signed [robi_pkg::INV_W-1:0] qs;
    int dim;
    logic sgn;

    for (int k = 1; k < NST; k++) pipe_d[k] = pipe_q[k-1];
    pipe_d[0] = pipe_q[0];

    // Stage REL: capture the ray and form origin - center.
    pipe_d[robi_pkg::ST_REL].org[0] = in_data_i.origin_x;
    pipe_d[robi_pkg::ST_REL].org[1] = in_data_i.origin_y;
    pipe_d[robi_pkg::ST_REL].org[2] = in_data_i.origin_z;
    pipe_d[robi_pkg::ST_REL].dir[0] = in_data_i.dir_x;
    pipe_d[robi_pkg::ST_REL].dir[1] = in_data_i.dir_y;
    pipe_d[robi_pkg::ST_REL].dir[2] = in_data_i.dir_z;
    pipe_d[robi_pkg::ST_REL].near_v = in_data_i.near_limit;
    pipe_d[robi_pkg::ST_REL].far_v  = in_data_i.far_limit;
    for (int i = 0; i < 3; i++) begin
      pipe_d[robi_pkg::ST_REL].rel[i] = robi_pkg::VEC_W'(pipe_d[robi_pkg::ST_REL].org[i])
                                       - robi_pkg::VEC_W'(cen[i]);
    end

    // Stage SLAB: direction sign and magnitude, saturated slab distances.
    for (int i = 0; i < 3; i++) begin
      pipe_d[robi_pkg::ST_SLAB].dneg[i]  = rot_dd[i] < 0;
      pipe_d[robi_pkg::ST_SLAB].dzero[i] = rot_dd[i] == 0;
      mag[i] = (rot_dd[i] < 0) ? robi_pkg::MAG_W'(-rot_dd[i]) : robi_pkg::MAG_W'(rot_dd[i]);
      hw = 64'(half[i]);
      pw = 64'(rot_p[i]);
      pipe_d[robi_pkg::ST_SLAB].a[i] = robi_pkg::sat_slab(-hw - pw);
      pipe_d[robi_pkg::ST_SLAB].b[i] = robi_pkg::sat_slab(hw - pw);
    end

    // Stage INV: saturate the quotient, zero counts as positive, apply sign.
    for (int i = 0; i < 3; i++) begin
      qm = (quo[i][robi_pkg::DIV_BITS-1:robi_pkg::INV_W-1] != '0)
         ? robi_pkg::INV_MAX[robi_pkg::INV_W-2:0] : quo[i][robi_pkg::INV_W-2:0];
      qs = $signed({1'b0, qm});
      if (pipe_q[robi_pkg::ST_INV-1].dzero[i]) begin
        pipe_d[robi_pkg::ST_INV].inv[i] = robi_pkg::INV_MAX;
      end else if (pipe_q[robi_pkg::ST_INV-1].dneg[i]) begin
        pipe_d[robi_pkg::ST_INV].inv[i] = -qs;
      end else begin
        pipe_d[robi_pkg::ST_INV].inv[i] = qs;
      end
    end

    // Stage MUL: slab distance times reciprocal.
    for (int i = 0; i < 3; i++) begin
      pipe_d[robi_pkg::ST_MUL].pa[i] = pipe_q[robi_pkg::ST_INV].a[i]
                                     * pipe_q[robi_pkg::ST_INV].inv[i];
      pipe_d[robi_pkg::ST_MUL].pb[i] = pipe_q[robi_pkg::ST_INV].b[i]
                                     * pipe_q[robi_pkg::ST_INV].inv[i];
    end

    // Stage TSAT: back to Q12.12, saturated.
    for (int i = 0; i < 3; i++) begin
      pipe_d[robi_pkg::ST_TSAT].ta[i] = robi_pkg::sat_t(pipe_q[robi_pkg::ST_MUL].pa[i] >>> 16);
      pipe_d[robi_pkg::ST_TSAT].tb[i] = robi_pkg::sat_t(pipe_q[robi_pkg::ST_MUL].pb[i] >>> 16);
    end

    // Stage CLIP: narrow the interval axis by axis, then pick t.
    lo = pipe_q[robi_pkg::ST_TSAT].near_v;
    hi = pipe_q[robi_pkg::ST_TSAT].far_v;
    for (int i = 0; i < 3; i++) begin
      if (!pipe_q[robi_pkg::ST_TSAT].inv[i][robi_pkg::INV_W-1]) begin
        if (pipe_q[robi_pkg::ST_TSAT].ta[i] > lo) lo = pipe_q[robi_pkg::ST_TSAT].ta[i];
        if (pipe_q[robi_pkg::ST_TSAT].tb[i] < hi) hi = pipe_q[robi_pkg::ST_TSAT].tb[i];
      end else begin
        if (pipe_q[robi_pkg::ST_TSAT].ta[i] < hi) hi = pipe_q[robi_pkg::ST_TSAT].ta[i];
        if (pipe_q[robi_pkg::ST_TSAT].tb[i] > lo) lo = pipe_q[robi_pkg::ST_TSAT].tb[i];
      end
    end
    pipe_d[robi_pkg::ST_CLIP].hit = !(lo > hi);
    if (lo > pipe_q[robi_pkg::ST_TSAT].near_v && lo < pipe_q[robi_pkg::ST_TSAT].far_v) begin
      pipe_d[robi_pkg::ST_CLIP].t = lo;
    end else if (hi > pipe_q[robi_pkg::ST_TSAT].near_v
                 && hi < pipe_q[robi_pkg::ST_TSAT].far_v) begin
      pipe_d[robi_pkg::ST_CLIP].t = hi;
    end else begin
      pipe_d[robi_pkg::ST_CLIP].t = robi_pkg::T_ONE;
    end

    // Stage TMUL: t times direction.
    for (int i = 0; i < 3; i++) begin
      pipe_d[robi_pkg::ST_TMUL].tp[i] = pipe_q[robi_pkg::ST_CLIP].t
                                      * pipe_q[robi_pkg::ST_CLIP].dir[i];
    end

    // Stage PT: hit point, saturated, and its offset from the center.
    for (int i = 0; i < 3; i++) begin
      wide = 64'(pipe_q[robi_pkg::ST_TMUL].org[i]) + 64'(pipe_q[robi_pkg::ST_TMUL].tp[i] >>> 18);
      pipe_d[robi_pkg::ST_PT].pt[i]  = robi_pkg::sat_c(wide);
      pipe_d[robi_pkg::ST_PT].rel[i] = robi_pkg::VEC_W'(pipe_d[robi_pkg::ST_PT].pt[i])
                                     - robi_pkg::VEC_W'(cen[i]);
    end

    // Stage OUT: face of largest excess, later axis wins ties.
    for (int i = 0; i < 3; i++) begin
      rv = 64'(rot_l[i]);
      e[i] = ((rv < 0) ? -rv : rv) - 64'(half[i]);
    end
    if (e[0] > e[1]) dim = (e[0] > e[2]) ? 0 : 2;
    else             dim = (e[1] > e[2]) ? 1 : 2;
    sgn = rot_l[dim] < 0;
    for (int i = 0; i < 3; i++) begin
      rv = 64'(rot[dim][i]);
      nv = sgn ? -rv : rv;
      pipe_d[robi_pkg::ST_OUT].nrm[i] = robi_pkg::sat_r(nv);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) pipe_q[k] <= pipe_d[k];
    end
  end

  // Miss: all result fields but the flag read zero.
  always_comb begin
    out_data_o.hit = pipe_q[NST-1].hit;
    if (pipe_q[NST-1].hit) begin
      out_data_o.hit_t    = pipe_q[NST-1].t;
      out_data_o.point_x  = pipe_q[NST-1].pt[0];
      out_data_o.point_y  = pipe_q[NST-1].pt[1];
      out_data_o.point_z  = pipe_q[NST-1].pt[2];
      out_data_o.normal_x = pipe_q[NST-1].nrm[0];
      out_data_o.normal_y = pipe_q[NST-1].nrm[1];
      out_data_o.normal_z = pipe_q[NST-1].nrm[2];
    end else begin
      out_data_o.hit_t    = '0;
      out_data_o.point_x  = '0;
      out_data_o.point_y  = '0;
      out_data_o.point_z  = '0;
      out_data_o.normal_x = '0;
      out_data_o.normal_y = '0;
      out_data_o.normal_z = '0;
    end
  end

endmodule
`default_nettype wire
